[rtl/h263_tcoef_vlc_encoder_assert.svh]
// ----------------------------------------------------------------------------
// H.263 TCOEF VLC encoder assertion macros
// Concurrent property helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef H263_TCOEF_VLC_ENCODER_ASSERT_SVH
`define H263_TCOEF_VLC_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define TCOEF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcoef vlc assertion failed");

// Next-cycle implication.
`define TCOEF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcoef vlc assertion failed");

`endif

[rtl/tcoef_pkg.sv]
// ----------------------------------------------------------------------------
// tcoef_pkg
// Constants, table entry type and the TCOEF (last, run, level) code table.
// ----------------------------------------------------------------------------
package tcoef_pkg;

    localparam int TABLE_SIZE  = 102;
    localparam int LAST1_START = 58;

    localparam logic [6:0] ESC_MARKER = 7'b0000011;
    localparam logic [4:0] ESC_LEN    = 5'd22;

    // Length is without the sign bit.
    typedef struct packed {
        logic [5:0] run;
        logic [3:0] mag;
        logic [3:0] len;
        logic [6:0] code;
    } entry_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] len;
        logic [6:0] code;
    } lookup_t;

    localparam entry_t TCOEF_TAB [TABLE_SIZE] = '{
        // last = 0
        '{6'd0, 4'd1, 4'd2, 7'h02}, '{6'd0, 4'd2, 4'd4, 7'h0F},
        '{6'd0, 4'd3, 4'd6, 7'h15}, '{6'd0, 4'd4, 4'd7, 7'h17},
        '{6'd0, 4'd5, 4'd8, 7'h1F}, '{6'd0, 4'd6, 4'd9, 7'h25},
        '{6'd0, 4'd7, 4'd9, 7'h24}, '{6'd0, 4'd8, 4'd10, 7'h21},
        '{6'd0, 4'd9, 4'd10, 7'h20}, '{6'd0, 4'd10, 4'd11, 7'h07},
        '{6'd0, 4'd11, 4'd11, 7'h06}, '{6'd0, 4'd12, 4'd11, 7'h20},
        '{6'd1, 4'd1, 4'd3, 7'h06}, '{6'd1, 4'd2, 4'd6, 7'h14},
        '{6'd1, 4'd3, 4'd8, 7'h1E}, '{6'd1, 4'd4, 4'd10, 7'h0F},
        '{6'd1, 4'd5, 4'd11, 7'h21}, '{6'd1, 4'd6, 4'd12, 7'h50},
        '{6'd2, 4'd1, 4'd4, 7'h0E}, '{6'd2, 4'd2, 4'd8, 7'h1D},
        '{6'd2, 4'd3, 4'd10, 7'h0E}, '{6'd2, 4'd4, 4'd12, 7'h51},
        '{6'd3, 4'd1, 4'd5, 7'h0D}, '{6'd3, 4'd2, 4'd9, 7'h23},
        '{6'd3, 4'd3, 4'd10, 7'h0D},
        '{6'd4, 4'd1, 4'd5, 7'h0C}, '{6'd4, 4'd2, 4'd9, 7'h22},
        '{6'd4, 4'd3, 4'd12, 7'h52},
        '{6'd5, 4'd1, 4'd5, 7'h0B}, '{6'd5, 4'd2, 4'd10, 7'h0C},
        '{6'd5, 4'd3, 4'd12, 7'h53},
        '{6'd6, 4'd1, 4'd6, 7'h13}, '{6'd6, 4'd2, 4'd10, 7'h0B},
        '{6'd6, 4'd3, 4'd12, 7'h54},
        '{6'd7, 4'd1, 4'd6, 7'h12}, '{6'd7, 4'd2, 4'd10, 7'h0A},
        '{6'd8, 4'd1, 4'd6, 7'h11}, '{6'd8, 4'd2, 4'd10, 7'h09},
        '{6'd9, 4'd1, 4'd6, 7'h10}, '{6'd9, 4'd2, 4'd10, 7'h08},
        '{6'd10, 4'd1, 4'd7, 7'h16}, '{6'd10, 4'd2, 4'd12, 7'h55},
        '{6'd11, 4'd1, 4'd7, 7'h15}, '{6'd12, 4'd1, 4'd7, 7'h14},
        '{6'd13, 4'd1, 4'd8, 7'h1C}, '{6'd14, 4'd1, 4'd8, 7'h1B},
        '{6'd15, 4'd1, 4'd9, 7'h21}, '{6'd16, 4'd1, 4'd9, 7'h20},
        '{6'd17, 4'd1, 4'd9, 7'h1F}, '{6'd18, 4'd1, 4'd9, 7'h1E},
        '{6'd19, 4'd1, 4'd9, 7'h1D}, '{6'd20, 4'd1, 4'd9, 7'h1C},
        '{6'd21, 4'd1, 4'd9, 7'h1B}, '{6'd22, 4'd1, 4'd9, 7'h1A},
        '{6'd23, 4'd1, 4'd11, 7'h22}, '{6'd24, 4'd1, 4'd11, 7'h23},
        '{6'd25, 4'd1, 4'd12, 7'h56}, '{6'd26, 4'd1, 4'd12, 7'h57},
        // last = 1
        '{6'd0, 4'd1, 4'd4, 7'h07}, '{6'd0, 4'd2, 4'd9, 7'h19},
        '{6'd0, 4'd3, 4'd11, 7'h05},
        '{6'd1, 4'd1, 4'd6, 7'h0F}, '{6'd1, 4'd2, 4'd11, 7'h04},
        '{6'd2, 4'd1, 4'd6, 7'h0E}, '{6'd3, 4'd1, 4'd6, 7'h0D},
        '{6'd4, 4'd1, 4'd6, 7'h0C},
        '{6'd5, 4'd1, 4'd7, 7'h13}, '{6'd6, 4'd1, 4'd7, 7'h12},
        '{6'd7, 4'd1, 4'd7, 7'h11}, '{6'd8, 4'd1, 4'd7, 7'h10},
        '{6'd9, 4'd1, 4'd8, 7'h1A}, '{6'd10, 4'd1, 4'd8, 7'h19},
        '{6'd11, 4'd1, 4'd8, 7'h18}, '{6'd12, 4'd1, 4'd8, 7'h17},
        '{6'd13, 4'd1, 4'd8, 7'h16}, '{6'd14, 4'd1, 4'd8, 7'h15},
        '{6'd15, 4'd1, 4'd8, 7'h14}, '{6'd16, 4'd1, 4'd8, 7'h13},
        '{6'd17, 4'd1, 4'd9, 7'h18}, '{6'd18, 4'd1, 4'd9, 7'h17},
        '{6'd19, 4'd1, 4'd9, 7'h16}, '{6'd20, 4'd1, 4'd9, 7'h15},
        '{6'd21, 4'd1, 4'd9, 7'h14}, '{6'd22, 4'd1, 4'd9, 7'h13},
        '{6'd23, 4'd1, 4'd9, 7'h12}, '{6'd24, 4'd1, 4'd9, 7'h11},
        '{6'd25, 4'd1, 4'd10, 7'h07}, '{6'd26, 4'd1, 4'd10, 7'h06},
        '{6'd27, 4'd1, 4'd10, 7'h05}, '{6'd28, 4'd1, 4'd10, 7'h04},
        '{6'd29, 4'd1, 4'd11, 7'h24}, '{6'd30, 4'd1, 4'd11, 7'h25},
        '{6'd31, 4'd1, 4'd11, 7'h26}, '{6'd32, 4'd1, 4'd11, 7'h27},
        '{6'd33, 4'd1, 4'd12, 7'h58}, '{6'd34, 4'd1, 4'd12, 7'h59},
        '{6'd35, 4'd1, 4'd12, 7'h5A}, '{6'd36, 4'd1, 4'd12, 7'h5B},
        '{6'd37, 4'd1, 4'd12, 7'h5C}, '{6'd38, 4'd1, 4'd12, 7'h5D},
        '{6'd39, 4'd1, 4'd12, 7'h5E}, '{6'd40, 4'd1, 4'd12, 7'h5F}
    };

    // Parallel match against every entry; entries are unique so an OR merge is exact.
    function automatic lookup_t tcoef_lookup(
        input logic       last,
        input logic [5:0] run,
        input logic [7:0] mag
    );
        lookup_t res;
        logic    entry_last;
        res = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            entry_last = (i >= LAST1_START);
            if ((entry_last == last) && (TCOEF_TAB[i].run == run) &&
                (mag[7:4] == 4'd0) && (TCOEF_TAB[i].mag == mag[3:0])) begin
                res.hit  = 1'b1;
                res.len  = res.len  | TCOEF_TAB[i].len;
                res.code = res.code | TCOEF_TAB[i].code;
            end
        end
        return res;
    endfunction

endpackage

[rtl/h263_tcoef_vlc_encoder.sv]
// ----------------------------------------------------------------------------
// h263_tcoef_vlc_encoder
// H.263 (LAST, RUN, LEVEL) coefficient VLC encoder, three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: last_flag, zero_run, coef_level are taken at a rising
//   edge where start is high and busy is low. busy is never raised, so one
//   item can be taken every cycle.
//   Output channel: done is high for one cycle with code_bits (right-
//   aligned, MSB first) and code_length. Results come out in input order.
//   Pipeline: an accepted item passes the magnitude stage, the table match
//   stage and the output assembly stage, whose registers drive done and the
//   result. Throughput: 1 item/cycle.
//   Table hit: table code with sign appended as LSB, length = table len + 1.
//   Miss (incl. level zero and -128): 22-bit escape 0000011,last,run,level.
//   Reset: clears the stage valid bits; no item is in flight afterwards.
//   The receiver cannot stall; every result is shown for one cycle only.
// ----------------------------------------------------------------------------
`include "h263_tcoef_vlc_encoder_assert.svh"

module h263_tcoef_vlc_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        last_flag,
    input  logic [5:0]  zero_run,
    input  logic signed [7:0] coef_level,
    output logic        done,
    output logic [21:0] code_bits,
    output logic [4:0]  code_length
);

    // stage 1: input capture with magnitude
    logic       s1_valid_reg;
    logic       s1_last_reg;
    logic [5:0] s1_run_reg;
    logic [7:0] s1_lev_reg;
    logic [7:0] s1_mag_reg;
    logic [7:0] s1_mag_next;

    // stage 2: table match
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [5:0]         s2_run_reg;
    logic [7:0]         s2_lev_reg;
    tcoef_pkg::lookup_t s2_lut_reg;
    tcoef_pkg::lookup_t s2_lut_next;

    // stage 3: output
    logic        done_reg;
    logic [21:0] code_bits_reg;
    logic [21:0] code_bits_next;
    logic [4:0]  code_length_reg;
    logic [4:0]  code_length_next;

    assign busy = 1'b0;

    // -128 yields 0x80, which is outside the table and escapes.
    assign s1_mag_next = coef_level[7] ? (8'd0 - coef_level) : coef_level;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        s1_last_reg     <= last_flag;
        s1_run_reg      <= zero_run;
        s1_lev_reg      <= coef_level;
        s1_mag_reg      <= s1_mag_next;
        s2_last_reg     <= s1_last_reg;
        s2_run_reg      <= s1_run_reg;
        s2_lev_reg      <= s1_lev_reg;
        s2_lut_reg      <= s2_lut_next;
        code_bits_reg   <= code_bits_next;
        code_length_reg <= code_length_next;
    end

    always_comb begin
        s2_lut_next = tcoef_pkg::tcoef_lookup(s1_last_reg, s1_run_reg, s1_mag_reg);
    end

    always_comb begin
        if (s2_lut_reg.hit) begin
            code_bits_next   = {14'd0, s2_lut_reg.code, s2_lev_reg[7]};
            code_length_next = {1'b0, s2_lut_reg.len} + 5'd1;
        end
        else begin
            code_bits_next   = {tcoef_pkg::ESC_MARKER, s2_last_reg, s2_run_reg, s2_lev_reg};
            code_length_next = tcoef_pkg::ESC_LEN;
        end
    end

    assign done        = done_reg;
    assign code_bits   = code_bits_reg;
    assign code_length = code_length_reg;

    // an accepted item shows up on done after the s1, s2 and output registers, and nothing else does
    `TCOEF_ASSERT_IMPL(a_latency, $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3), done == $past(start && !busy, 3))
    // escape length and escape marker go together
    `TCOEF_ASSERT_IMPL(a_escape, done, (code_length == tcoef_pkg::ESC_LEN) == (code_bits[21:15] == tcoef_pkg::ESC_MARKER))
    // table codes carry no bits above their length
    `TCOEF_ASSERT_IMPL(a_code_fits, done && (code_length != tcoef_pkg::ESC_LEN), (code_bits >> code_length) == 22'd0)
    // one result per accepted item: done never repeats unless start kept coming
    `TCOEF_ASSERT_NEXT(a_no_repeat, done && !$past(start && !busy, 2), !done)

endmodule

[sim/h263_tcoef_vlc_encoder_test.sv]
// ----------------------------------------------------------------------------
// h263_tcoef_vlc_encoder_test
// Self-checking bench for the H.263 (LAST, RUN, LEVEL) VLC encoder. A table of
// corner-case coefficient events runs first, followed by about 500 random
// events. Most random events land on code table entries and the rest are
// escapes or fully random fields. The sender inserts idle gaps, some chunks
// run back to back, and the sender waits for all results to drain after the
// directed table, before the sixth chunk and at the end. Every done pulse is
// checked field by field against a typed-in answer or the local encoder model.
// ----------------------------------------------------------------------------
module h263_tcoef_vlc_encoder_test;

    localparam int         CODE_COUNT    = 102;
    localparam int         LAST_ONE_BASE = 58;
    localparam logic [6:0] ESC_PREFIX    = 7'b0000011;
    localparam logic [4:0] ESC_LENGTH    = 5'd22;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         CHUNK_SIZE    = 50;
    localparam int         CHUNK_COUNT   = 10;

    // {run, magnitude, length without sign, code}
    localparam logic [20:0] VLC_CODES [CODE_COUNT] = '{
        // last = 0
        {6'd0, 4'd1, 4'd2, 7'h02},   {6'd0, 4'd2, 4'd4, 7'h0F},
        {6'd0, 4'd3, 4'd6, 7'h15},   {6'd0, 4'd4, 4'd7, 7'h17},
        {6'd0, 4'd5, 4'd8, 7'h1F},   {6'd0, 4'd6, 4'd9, 7'h25},
        {6'd0, 4'd7, 4'd9, 7'h24},   {6'd0, 4'd8, 4'd10, 7'h21},
        {6'd0, 4'd9, 4'd10, 7'h20},  {6'd0, 4'd10, 4'd11, 7'h07},
        {6'd0, 4'd11, 4'd11, 7'h06}, {6'd0, 4'd12, 4'd11, 7'h20},
        {6'd1, 4'd1, 4'd3, 7'h06},   {6'd1, 4'd2, 4'd6, 7'h14},
        {6'd1, 4'd3, 4'd8, 7'h1E},   {6'd1, 4'd4, 4'd10, 7'h0F},
        {6'd1, 4'd5, 4'd11, 7'h21},  {6'd1, 4'd6, 4'd12, 7'h50},
        {6'd2, 4'd1, 4'd4, 7'h0E},   {6'd2, 4'd2, 4'd8, 7'h1D},
        {6'd2, 4'd3, 4'd10, 7'h0E},  {6'd2, 4'd4, 4'd12, 7'h51},
        {6'd3, 4'd1, 4'd5, 7'h0D},   {6'd3, 4'd2, 4'd9, 7'h23},
        {6'd3, 4'd3, 4'd10, 7'h0D},  {6'd4, 4'd1, 4'd5, 7'h0C},
        {6'd4, 4'd2, 4'd9, 7'h22},   {6'd4, 4'd3, 4'd12, 7'h52},
        {6'd5, 4'd1, 4'd5, 7'h0B},   {6'd5, 4'd2, 4'd10, 7'h0C},
        {6'd5, 4'd3, 4'd12, 7'h53},  {6'd6, 4'd1, 4'd6, 7'h13},
        {6'd6, 4'd2, 4'd10, 7'h0B},  {6'd6, 4'd3, 4'd12, 7'h54},
        {6'd7, 4'd1, 4'd6, 7'h12},   {6'd7, 4'd2, 4'd10, 7'h0A},
        {6'd8, 4'd1, 4'd6, 7'h11},   {6'd8, 4'd2, 4'd10, 7'h09},
        {6'd9, 4'd1, 4'd6, 7'h10},   {6'd9, 4'd2, 4'd10, 7'h08},
        {6'd10, 4'd1, 4'd7, 7'h16},  {6'd10, 4'd2, 4'd12, 7'h55},
        {6'd11, 4'd1, 4'd7, 7'h15},  {6'd12, 4'd1, 4'd7, 7'h14},
        {6'd13, 4'd1, 4'd8, 7'h1C},  {6'd14, 4'd1, 4'd8, 7'h1B},
        {6'd15, 4'd1, 4'd9, 7'h21},  {6'd16, 4'd1, 4'd9, 7'h20},
        {6'd17, 4'd1, 4'd9, 7'h1F},  {6'd18, 4'd1, 4'd9, 7'h1E},
        {6'd19, 4'd1, 4'd9, 7'h1D},  {6'd20, 4'd1, 4'd9, 7'h1C},
        {6'd21, 4'd1, 4'd9, 7'h1B},  {6'd22, 4'd1, 4'd9, 7'h1A},
        {6'd23, 4'd1, 4'd11, 7'h22}, {6'd24, 4'd1, 4'd11, 7'h23},
        {6'd25, 4'd1, 4'd12, 7'h56}, {6'd26, 4'd1, 4'd12, 7'h57},
        // last = 1
        {6'd0, 4'd1, 4'd4, 7'h07},   {6'd0, 4'd2, 4'd9, 7'h19},
        {6'd0, 4'd3, 4'd11, 7'h05},  {6'd1, 4'd1, 4'd6, 7'h0F},
        {6'd1, 4'd2, 4'd11, 7'h04},  {6'd2, 4'd1, 4'd6, 7'h0E},
        {6'd3, 4'd1, 4'd6, 7'h0D},   {6'd4, 4'd1, 4'd6, 7'h0C},
        {6'd5, 4'd1, 4'd7, 7'h13},   {6'd6, 4'd1, 4'd7, 7'h12},
        {6'd7, 4'd1, 4'd7, 7'h11},   {6'd8, 4'd1, 4'd7, 7'h10},
        {6'd9, 4'd1, 4'd8, 7'h1A},   {6'd10, 4'd1, 4'd8, 7'h19},
        {6'd11, 4'd1, 4'd8, 7'h18},  {6'd12, 4'd1, 4'd8, 7'h17},
        {6'd13, 4'd1, 4'd8, 7'h16},  {6'd14, 4'd1, 4'd8, 7'h15},
        {6'd15, 4'd1, 4'd8, 7'h14},  {6'd16, 4'd1, 4'd8, 7'h13},
        {6'd17, 4'd1, 4'd9, 7'h18},  {6'd18, 4'd1, 4'd9, 7'h17},
        {6'd19, 4'd1, 4'd9, 7'h16},  {6'd20, 4'd1, 4'd9, 7'h15},
        {6'd21, 4'd1, 4'd9, 7'h14},  {6'd22, 4'd1, 4'd9, 7'h13},
        {6'd23, 4'd1, 4'd9, 7'h12},  {6'd24, 4'd1, 4'd9, 7'h11},
        {6'd25, 4'd1, 4'd10, 7'h07}, {6'd26, 4'd1, 4'd10, 7'h06},
        {6'd27, 4'd1, 4'd10, 7'h05}, {6'd28, 4'd1, 4'd10, 7'h04},
        {6'd29, 4'd1, 4'd11, 7'h24}, {6'd30, 4'd1, 4'd11, 7'h25},
        {6'd31, 4'd1, 4'd11, 7'h26}, {6'd32, 4'd1, 4'd11, 7'h27},
        {6'd33, 4'd1, 4'd12, 7'h58}, {6'd34, 4'd1, 4'd12, 7'h59},
        {6'd35, 4'd1, 4'd12, 7'h5A}, {6'd36, 4'd1, 4'd12, 7'h5B},
        {6'd37, 4'd1, 4'd12, 7'h5C}, {6'd38, 4'd1, 4'd12, 7'h5D},
        {6'd39, 4'd1, 4'd12, 7'h5E}, {6'd40, 4'd1, 4'd12, 7'h5F}
    };

    typedef struct packed {
        logic [21:0] bits;
        logic [4:0]  len;
    } vlc_word_t;

    // Directed event; known = 1 means bits/len are the typed-in answer.
    typedef struct packed {
        logic        last;
        logic [5:0]  run;
        logic [7:0]  level;
        logic        known;
        logic [21:0] bits;
        logic [4:0]  len;
    } probe_t;

    localparam int PROBE_COUNT = 24;
    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{1'b0, 6'd0,  8'h01, 1'b1, 22'h000004, 5'd3},    // shortest code, +1
        '{1'b0, 6'd0,  8'hFF, 1'b1, 22'h000005, 5'd3},    // shortest code, -1
        '{1'b0, 6'd0,  8'h0C, 1'b1, 22'h000040, 5'd12},   // largest table level
        '{1'b0, 6'd0,  8'hF4, 1'b1, 22'h000041, 5'd12},
        '{1'b0, 6'd0,  8'h0D, 1'b1, 22'h01800D, 5'd22},   // one past the table
        '{1'b0, 6'd0,  8'h00, 1'b1, 22'h018000, 5'd22},   // level zero
        '{1'b1, 6'd0,  8'h00, 1'b1, 22'h01C000, 5'd22},
        '{1'b1, 6'd63, 8'h80, 1'b1, 22'h01FF80, 5'd22},   // level -128, max run
        '{1'b0, 6'd63, 8'h7F, 1'b1, 22'h01BF7F, 5'd22},
        '{1'b0, 6'd26, 8'h01, 1'b1, 22'h0000AE, 5'd13},   // longest run, last=0
        '{1'b0, 6'd27, 8'h01, 1'b1, 22'h019B01, 5'd22},
        '{1'b1, 6'd40, 8'h01, 1'b1, 22'h0000BE, 5'd13},   // longest run, last=1
        '{1'b1, 6'd40, 8'hFF, 1'b1, 22'h0000BF, 5'd13},
        '{1'b1, 6'd41, 8'h01, 1'b1, 22'h01E901, 5'd22},
        '{1'b1, 6'd0,  8'h03, 1'b1, 22'h00000A, 5'd12},
        '{1'b1, 6'd0,  8'h04, 1'b1, 22'h01C004, 5'd22},
        '{1'b0, 6'd0,  8'h11, 1'b1, 22'h018011, 5'd22},   // low nibble aliases 1
        '{1'b0, 6'd0,  8'hEF, 1'b1, 22'h0180EF, 5'd22},
        '{1'b0, 6'd0,  8'h7F, 1'b1, 22'h01807F, 5'd22},
        '{1'b0, 6'd1,  8'h06, 1'b0, 22'h0, 5'd0},
        '{1'b0, 6'd10, 8'hFE, 1'b0, 22'h0, 5'd0},
        '{1'b1, 6'd33, 8'h01, 1'b0, 22'h0, 5'd0},
        '{1'b0, 6'd25, 8'hFF, 1'b0, 22'h0, 5'd0},
        '{1'b1, 6'd0,  8'h80, 1'b0, 22'h0, 5'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              last_flag = 1'b0;
    logic [5:0]        zero_run = 6'd0;
    logic signed [7:0] coef_level = 8'sd0;
    logic              done;
    logic [21:0]       code_bits;
    logic [4:0]        code_length;

    // Typed-in answer riding along with the item on the input side.
    logic              probe_known = 1'b0;
    vlc_word_t         probe_word = '0;

    vlc_word_t         pending_codes [$];
    vlc_word_t         want;
    int                mismatches = 0;
    int                codes_checked = 0;
    int                escapes_seen = 0;
    int                cycle_count = 0;

    h263_tcoef_vlc_encoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .last_flag   (last_flag),
        .zero_run    (zero_run),
        .coef_level  (coef_level),
        .done        (done),
        .code_bits   (code_bits),
        .code_length (code_length)
    );

    always #6 clk = ~clk;

    function automatic vlc_word_t encode_event(
        input logic       last,
        input logic [5:0] run,
        input logic [7:0] level
    );
        vlc_word_t   word;
        logic        neg;
        logic [7:0]  mag;
        logic [20:0] entry;
        int          lo;
        int          hi;
        neg  = level[7];
        mag  = neg ? 8'(-level) : level;
        lo   = last ? LAST_ONE_BASE : 0;
        hi   = last ? CODE_COUNT : LAST_ONE_BASE;
        word = '{{ESC_PREFIX, last, run, level}, ESC_LENGTH};
        for (int i = lo; i < hi; i++) begin
            entry = VLC_CODES[i];
            if (entry[20:15] == run && {4'd0, entry[14:11]} == mag) begin
                word.bits = 22'({entry[6:0], neg});
                word.len  = 5'(entry[10:7]) + 5'd1;
            end
        end
        return word;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Present one item and hold it until the accepting edge.
    task automatic send_event(
        input logic       last,
        input logic [5:0] run,
        input logic [7:0] level,
        input logic       known,
        input vlc_word_t  answer,
        input bit         allow_gap
    );
        int gap;
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0)
        begin
            start      <= 1'b0;
            last_flag  <= 1'($urandom);
            zero_run   <= 6'($urandom);
            coef_level <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        last_flag   <= last;
        zero_run    <= run;
        coef_level  <= level;
        probe_known <= known;
        probe_word  <= answer;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        do @(posedge clk); while (pending_codes.size() != 0);
    endtask

    // Mostly real table events with random sign; the rest escapes and noise.
    task automatic random_event(output logic last, output logic [5:0] run,
                                output logic [7:0] level);
        int          kind;
        int          idx;
        logic [20:0] entry;
        logic [7:0]  mag;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            idx   = $urandom_range(0, CODE_COUNT - 1);
            entry = VLC_CODES[idx];
            last  = (idx >= LAST_ONE_BASE);
            run   = entry[20:15];
            mag   = {4'd0, entry[14:11]};
            level = $urandom_range(0, 1) ? 8'(-mag) : mag;
        end
        else if (kind < 8)
        begin
            last  = 1'($urandom);
            run   = 6'($urandom);
            level = 8'($urandom);
        end
        else if (kind == 8)
        begin
            last = 1'($urandom);
            run  = 6'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0: level = 8'h00;
                1: level = 8'h80;
                default: level = 8'($urandom_range(13, 16)) ^ {8{1'($urandom)}};
            endcase
        end
        else
        begin
            // longest table run or first run past the table for this last value
            last  = 1'($urandom);
            run   = (last ? 6'd41 : 6'd27) - 6'($urandom_range(0, 1));
            level = $urandom_range(0, 1) ? 8'h01 : 8'hFF;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d codes still due",
                     $time, cycle_count, pending_codes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Expectations are queued at the accepting edge, results checked on done.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (probe_known)
                    pending_codes.push_back(probe_word);
                else
                    pending_codes.push_back(encode_event(last_flag, zero_run, coef_level));
            end
            if (done)
            begin
                codes_checked <= codes_checked + 1;
                if (code_length == ESC_LENGTH)
                    escapes_seen <= escapes_seen + 1;
                if (pending_codes.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected code bits=%06h len=%0d",
                             $time, code_bits, code_length);
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (code_bits !== want.bits)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: code_bits expected %06h got %06h",
                                 $time, want.bits, code_bits);
                    end
                    if (code_length !== want.len)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: code_length expected %0d got %0d",
                                 $time, want.len, code_length);
                    end
                end
            end
        end
    end

    initial
    begin
        logic       ev_last;
        logic [5:0] ev_run;
        logic [7:0] ev_level;
        bit         gaps_on;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PROBES[i])
            send_event(PROBES[i].last, PROBES[i].run, PROBES[i].level, PROBES[i].known,
                       '{PROBES[i].bits, PROBES[i].len}, 1'b1);
        wait_drain();

        for (int chunk = 0; chunk < CHUNK_COUNT; chunk++)
        begin
            // a couple of chunks run back to back
            gaps_on = !(chunk == 1 || chunk == 6);
            if (chunk == 5)
                wait_drain();
            for (int n = 0; n < CHUNK_SIZE; n++)
            begin
                random_event(ev_last, ev_run, ev_level);
                send_event(ev_last, ev_run, ev_level, 1'b0, '0, gaps_on);
            end
        end
        start <= 1'b0;

        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Encoded %0d coefficient events: %0d table codes, %0d escapes.",
                 codes_checked, codes_checked - escapes_seen, escapes_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_codes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tcoef_pkg.sv
rtl/h263_tcoef_vlc_encoder.sv
sim/h263_tcoef_vlc_encoder_test.sv
